// ===== hw/rtl/iir_lp_pkg.sv =====
// shared constants, types and coefficient table of the order-7 low-pass iir filter
`timescale 1ns / 1ps

package iir_lp_pkg;

    localparam int ORDER       = 7;
    localparam int SAMPLE_BITS = 16;
    localparam int Y_FRAC      = 32;
    localparam int Y_W         = SAMPLE_BITS + Y_FRAC;
    localparam int C_FRAC      = 56;
    localparam int COEF_W      = 64;
    localparam int HALF_W      = 32;
    localparam int OP_W        = HALF_W + 1;
    localparam int PROD_W      = 2 * OP_W;
    localparam int ACC_W       = COEF_W + Y_W + 4;
    localparam int NTAPS       = 2 * ORDER + 1;
    localparam int TAP_W       = $clog2(NTAPS);
    localparam int HIST_W      = $clog2(ORDER + 1);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [Y_W-1:0]         t_yval;
    typedef logic [COEF_W-1:0]             t_coef;
    typedef logic [TAP_W-1:0]              t_tap;
    // part[0]: upper coefficient half, part[1]: upper data half
    typedef logic [1:0]                    t_part;

    localparam t_part PART_FB_FIRST = 2'b00;
    localparam t_part PART_IN_FIRST = 2'b10;
    localparam t_part PART_LAST     = 2'b11;

    localparam t_tap FB_TAP   = TAP_W'(ORDER + 1);
    localparam t_tap LAST_TAP = TAP_W'(NTAPS - 1);

    typedef struct packed {
        logic  accept;
        logic  mul_en;
        t_tap  tap;
        t_part part;
        logic  round_en;
        logic  write_en;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    // decimal num/den to Q8.56, rounded half away from zero on the magnitude
    function automatic t_coef dec_to_q(input logic [63:0] num, input logic [63:0] den,
                                       input logic neg);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = num;
        for (int k = 0; k < 64; k++) begin
            if (r >= den) begin
                r = r - den;
                q = q + 64'd1;
            end
        end
        for (int k = 0; k < C_FRAC; k++) begin
            r = {r[62:0], 1'b0};
            q = {q[62:0], 1'b0};
            if (r >= den) begin
                r    = r - den;
                q[0] = 1'b1;
            end
        end
        r = {r[62:0], 1'b0};
        if (r >= den) begin
            q = q + 64'd1;
        end
        return neg ? (64'd0 - q) : q;
    endfunction

    // b0..b7, then the negated a1..a7; last slot pads the table to a power of two
    localparam t_coef COEF_TAB [2**TAP_W] = '{
        dec_to_q(64'd294123952,  64'd100000000000000000, 1'b0),
        dec_to_q(64'd205886766,  64'd10000000000000000,  1'b0),
        dec_to_q(64'd617660299,  64'd10000000000000000,  1'b0),
        dec_to_q(64'd102943383,  64'd1000000000000000,   1'b0),
        dec_to_q(64'd102943383,  64'd1000000000000000,   1'b0),
        dec_to_q(64'd617660299,  64'd10000000000000000,  1'b0),
        dec_to_q(64'd205886766,  64'd10000000000000000,  1'b0),
        dec_to_q(64'd294123952,  64'd100000000000000000, 1'b0),
        dec_to_q(64'd643532476,  64'd100000000,          1'b0),
        dec_to_q(64'd1776978865, 64'd100000000,          1'b1),
        dec_to_q(64'd2729100833, 64'd100000000,          1'b0),
        dec_to_q(64'd2517605177, 64'd100000000,          1'b1),
        dec_to_q(64'd1394983801, 64'd100000000,          1'b0),
        dec_to_q(64'd42985741,   64'd10000000,           1'b1),
        dec_to_q(64'd56824305,   64'd100000000,          1'b0),
        64'd0
    };

endpackage

// ===== hw/rtl/iir_lp_if.sv =====
// valid/ready channel interfaces for input samples and filtered samples
`timescale 1ns / 1ps

interface iir_lp_in_if;
    import iir_lp_pkg::*;
    logic    valid;
    logic    ready;
    t_sample sample_in;
    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface iir_lp_out_if;
    import iir_lp_pkg::*;
    logic    valid;
    logic    ready;
    t_sample filtered_sample;
    modport source (output valid, output filtered_sample, input ready);
    modport sink   (input valid, input filtered_sample, output ready);
endinterface

// ===== hw/rtl/iir_lp_ctrl.sv =====
// sequencer that walks taps and partial products and steps the datapath
`timescale 1ns / 1ps

module iir_lp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  iir_lp_pkg::t_sts  i_sts,
    output iir_lp_pkg::t_cmd  o_cmd
);
    import iir_lp_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;

    logic [2:0] r_state, n_state;
    t_tap       r_tap, n_tap;
    t_part      r_part, n_part;

    always_comb begin
        n_state      = r_state;
        n_tap        = r_tap;
        n_part       = r_part;
        o_cmd        = '0;
        o_cmd.tap    = r_tap;
        o_cmd.part   = r_part;
        o_in_ready   = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_MUL;
                    n_tap        = '0;
                    n_part       = PART_IN_FIRST;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                if (r_part == PART_LAST) begin
                    if (r_tap == LAST_TAP) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_tap  = r_tap + TAP_W'(1);
                        // feed-forward taps only need the upper data half
                        n_part = (n_tap < FB_TAP) ? PART_IN_FIRST : PART_FB_FIRST;
                    end
                end else begin
                    n_part = r_part + 2'd1;
                end
            end
            S_DRAIN: begin
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round_en = 1'b1;
                n_state        = S_WRITE;
            end
            S_WRITE: begin
                if (i_sts.out_free) begin
                    o_cmd.write_en = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= '0;
            r_part  <= PART_FB_FIRST;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
            r_part  <= n_part;
        end
    end

endmodule

// ===== hw/rtl/iir_lp_dp.sv =====
// histories, shared 33x33 multiplier, accumulator, rounding and output register
`timescale 1ns / 1ps

module iir_lp_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  iir_lp_pkg::t_cmd     i_cmd,
    input  iir_lp_pkg::t_sample  i_sample,
    output iir_lp_pkg::t_sts     o_sts,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output iir_lp_pkg::t_sample  o_out_sample
);
    import iir_lp_pkg::*;

    localparam int YW_TOP = ACC_W - C_FRAC;

    t_sample r_in_hist  [ORDER+1];
    t_yval   r_out_hist [ORDER+1];

    logic signed [PROD_W-1:0] r_prod;
    logic [1:0]               r_halves;
    logic                     r_acc_en;
    logic signed [ACC_W-1:0]  r_acc;
    t_yval                    r_y;
    logic                     r_out_valid;
    t_sample                  r_out_sample;

    t_coef                    coef;
    t_yval                    data;
    logic [HIST_W-1:0]        fb_idx;
    logic signed [OP_W-1:0]   a_op;
    logic signed [OP_W-1:0]   d_op;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  p_ext;
    logic signed [ACC_W-1:0]  p_shift;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic [YW_TOP-1:0]        y_wide;
    logic [YW_TOP-Y_W:0]      y_top;
    t_yval                    y_sat;
    logic [Y_W:0]             v;
    logic [SAMPLE_BITS:0]     o_wide;
    t_sample                  o_sat;

    // operand select for one partial product
    always_comb begin
        coef   = COEF_TAB[i_cmd.tap];
        fb_idx = i_cmd.tap[HIST_W-1:0] + HIST_W'(1);
        if (i_cmd.tap < FB_TAP) begin
            data = {r_in_hist[i_cmd.tap[HIST_W-1:0]], {Y_FRAC{1'b0}}};
        end else begin
            data = r_out_hist[fb_idx];
        end
        a_op = i_cmd.part[0] ? {coef[COEF_W-1], coef[COEF_W-1:HALF_W]}
                             : {1'b0, coef[HALF_W-1:0]};
        d_op = i_cmd.part[1] ? {{(OP_W-SAMPLE_BITS){data[Y_W-1]}}, data[Y_W-1:HALF_W]}
                             : {1'b0, data[HALF_W-1:0]};
        prod = a_op * d_op;
    end

    // align the registered partial product
    always_comb begin
        p_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        unique case (r_halves)
            2'd0:    p_shift = p_ext;
            2'd1:    p_shift = p_ext <<< HALF_W;
            default: p_shift = p_ext <<< (2 * HALF_W);
        endcase
    end

    // round to Q.32 and saturate to the history range
    always_comb begin
        acc_rnd = r_acc + (ACC_W'(1) <<< (C_FRAC - 1));
        y_wide  = acc_rnd[ACC_W-1:C_FRAC];
        y_top   = y_wide[YW_TOP-1:Y_W-1];
        if (!y_top[YW_TOP-Y_W] && (|y_top)) begin
            y_sat = {1'b0, {(Y_W-1){1'b1}}};
        end else if (y_top[YW_TOP-Y_W] && !(&y_top)) begin
            y_sat = {1'b1, {(Y_W-1){1'b0}}};
        end else begin
            y_sat = y_wide[Y_W-1:0];
        end
    end

    // round the history value to a sample and saturate
    always_comb begin
        v      = {r_y[Y_W-1], r_y} + ((Y_W+1)'(1) << (Y_FRAC - 1));
        o_wide = v[Y_W:Y_FRAC];
        unique case (o_wide[SAMPLE_BITS:SAMPLE_BITS-1])
            2'b01:   o_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            2'b10:   o_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            default: o_sat = o_wide[SAMPLE_BITS-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= ORDER; i++) begin
                r_in_hist[i]  <= '0;
                r_out_hist[i] <= '0;
            end
        end else begin
            if (i_cmd.accept) begin
                r_in_hist[0] <= i_sample;
                for (int i = 1; i <= ORDER; i++) begin
                    r_in_hist[i]  <= r_in_hist[i-1];
                    r_out_hist[i] <= r_out_hist[i-1];
                end
            end
            if (i_cmd.write_en) begin
                r_out_hist[0] <= r_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_en    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc_en <= i_cmd.mul_en;
            if (i_cmd.write_en) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= prod;
        r_halves <= {1'b0, i_cmd.part[0]} + {1'b0, i_cmd.part[1]};
        if (i_cmd.accept) begin
            r_acc <= '0;
        end else if (r_acc_en) begin
            r_acc <= r_acc + p_shift;
        end
        if (i_cmd.round_en) begin
            r_y <= y_sat;
        end
        if (i_cmd.write_en) begin
            r_out_sample <= o_sat;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_sample   = r_out_sample;

endmodule

// ===== hw/rtl/iir_lowpass_order7.sv =====
// top level of the seventh-order direct-form-I low-pass iir filter
`timescale 1ns / 1ps

// Seventh-order low-pass IIR filter, direct form I, fixed Q8.56 coefficients.
// One 16-bit signed sample in gives one rounded, saturated 16-bit sample out.
// A single 33x33 signed multiplier works through the fifteen taps, two partial
// products for each of the eight feed-forward taps and four for each of the
// seven feedback taps. A sample passes through the states accept, multiply,
// drain, round and write before its result is registered. The write waits while
// the previous result still sits unaccepted in the output register. The next
// sample is accepted the cycle after the write, while the previous result may
// still wait in the output register; no new sample is taken before the write.
// Histories reset to zero.
module iir_lowpass_order7 (
    input  logic          i_clk,
    input  logic          i_rst_n,
    iir_lp_in_if.sink     i_in,
    iir_lp_out_if.source  o_out
);
    import iir_lp_pkg::*;

    t_cmd    cmd;
    t_sts    sts;
    logic    in_ready;
    logic    out_valid;
    t_sample out_sample;

    iir_lp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    iir_lp_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_sample     (i_in.sample_in),
        .o_sts        (sts),
        .o_out_valid  (out_valid),
        .i_out_ready  (o_out.ready),
        .o_out_sample (out_sample)
    );

    assign i_in.ready            = in_ready;
    assign o_out.valid           = out_valid;
    assign o_out.filtered_sample = out_sample;

endmodule

// ===== hw/rtl/iir_lp_chk.sv =====
// port-level checks for the low-pass iir filter and their binding
`timescale 1ns / 1ps

module iir_lp_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input iir_lp_pkg::t_sample i_out_data
);
    import iir_lp_pkg::*;

    // a stalled word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_out_data))
        else $error("output word changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // one sample at a time
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken again while filtering");

    // a result only appears at the end of a computation
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result without a computation");

endmodule

bind iir_lowpass_order7 iir_lp_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.filtered_sample)
);

// ===== tb/iir_lp_check.sv =====
// checker for the order-7 low-pass iir filter: predicts each filtered word and compares
`timescale 1ns / 1ps

module iir_lp_check (
    input  logic  i_clk,
    input  logic  i_rst_n,
    iir_lp_in_if  i_smp,
    iir_lp_out_if i_flt,
    output int    o_fail_cnt,
    output int    o_pending,
    output int    o_word_cnt,
    output int    o_clip_cnt
);
    import iir_lp_pkg::*;

    typedef logic signed [127:0] t_wide;

    // b0..b7 then the negated a1..a7, as decimal num/den
    localparam logic [63:0] TAP_NUM [NTAPS] = '{
        64'd294123952, 64'd205886766, 64'd617660299, 64'd102943383,
        64'd102943383, 64'd617660299, 64'd205886766, 64'd294123952,
        64'd643532476, 64'd1776978865, 64'd2729100833, 64'd2517605177,
        64'd1394983801, 64'd42985741, 64'd56824305
    };
    localparam logic [63:0] TAP_DEN [NTAPS] = '{
        64'd100000000000000000, 64'd10000000000000000, 64'd10000000000000000,
        64'd1000000000000000, 64'd1000000000000000, 64'd10000000000000000,
        64'd10000000000000000, 64'd100000000000000000,
        64'd100000000, 64'd100000000, 64'd100000000, 64'd100000000,
        64'd100000000, 64'd10000000, 64'd100000000
    };
    localparam logic [NTAPS-1:0] TAP_NEG = 15'h2A00;

    localparam logic signed [63:0] Y_HI = (64'sd1 <<< (Y_W - 1)) - 64'sd1;
    localparam logic signed [63:0] Y_LO = -Y_HI - 64'sd1;
    localparam logic signed [63:0] S_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] S_LO = -S_HI - 64'sd1;

    logic signed [63:0] tap_q [NTAPS];
    t_sample            x_hist [ORDER+1];
    t_yval              y_hist [ORDER+1];
    t_sample            filtered_q [$];
    int                 fails;
    int                 words;
    int                 clips;

    // num/den scaled by 2^56, magnitude rounded half away from zero
    function automatic logic signed [63:0] to_q56(input logic [63:0] num,
                                                  input logic [63:0] den, input logic neg);
        logic [127:0] dbl;
        logic [63:0]  mag;
        dbl = ({64'd0, num} << (C_FRAC + 1)) / {64'd0, den};
        mag = 64'((dbl + 128'd1) >> 1);
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    initial begin
        for (int i = 0; i < NTAPS; i++) begin
            tap_q[i] = to_q56(TAP_NUM[i], TAP_DEN[i], TAP_NEG[i]);
        end
    end

    // shift the histories, run the fifteen taps, round and clamp
    function automatic t_sample lowpass_next(input t_sample s);
        t_wide              acc;
        t_wide              cw;
        t_wide              vw;
        logic signed [63:0] y64;
        logic signed [63:0] v;
        logic signed [63:0] o64;
        for (int i = ORDER; i > 0; i--) begin
            x_hist[i] = x_hist[i-1];
            y_hist[i] = y_hist[i-1];
        end
        x_hist[0] = s;
        acc = '0;
        for (int i = 0; i <= ORDER; i++) begin
            cw  = tap_q[i];
            vw  = x_hist[i];
            vw  = vw <<< Y_FRAC;
            acc = acc + cw * vw;
        end
        for (int i = 1; i <= ORDER; i++) begin
            cw  = tap_q[ORDER + i];
            vw  = y_hist[i];
            acc = acc + cw * vw;
        end
        acc = acc + (t_wide'(1) <<< (C_FRAC - 1));
        // guard bits above the 64-bit window must all match the sign
        if (acc[127 -: 9] == 9'h000 || acc[127 -: 9] == 9'h1FF) begin
            y64 = acc[C_FRAC + 63 : C_FRAC];
            if (y64 > Y_HI) y64 = Y_HI;
            if (y64 < Y_LO) y64 = Y_LO;
        end else begin
            y64 = acc[127] ? Y_LO : Y_HI;
        end
        y_hist[0] = t_yval'(y64);
        v   = y64 + (64'sd1 <<< (Y_FRAC - 1));
        o64 = v >>> Y_FRAC;
        if (o64 > S_HI) o64 = S_HI;
        if (o64 < S_LO) o64 = S_LO;
        return t_sample'(o64);
    endfunction

    always @(posedge i_clk) begin
        t_sample want;
        if (!i_rst_n) begin
            for (int i = 0; i <= ORDER; i++) begin
                x_hist[i] = '0;
                y_hist[i] = '0;
            end
            filtered_q.delete();
            fails = 0;
            words = 0;
            clips = 0;
        end else begin
            if (i_flt.valid && i_flt.ready) begin
                words++;
                if (filtered_q.size() == 0) begin
                    fails++;
                    $display("%0t: filtered word %0d arrived with none expected",
                             $time, i_flt.filtered_sample);
                end else begin
                    want = filtered_q.pop_front();
                    if (i_flt.filtered_sample !== want) begin
                        fails++;
                        $display("%0t: filtered_sample expected %0d got %0d",
                                 $time, want, i_flt.filtered_sample);
                    end
                end
            end
            if (i_smp.valid && i_smp.ready) begin
                want = lowpass_next(i_smp.sample_in);
                filtered_q.push_back(want);
                if (want == t_sample'(S_HI) || want == t_sample'(S_LO)) clips++;
            end
        end
        o_fail_cnt <= fails;
        o_pending  <= filtered_q.size();
        o_word_cnt <= words;
        o_clip_cnt <= clips;
    end

endmodule

// ===== tb/tb_iir_lowpass_order7.sv =====
// testbench top for the order-7 low-pass iir filter: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_iir_lowpass_order7;
    import iir_lp_pkg::*;

    localparam int N_ITEMS = 1900;
    localparam int LIMIT   = 1000000;
    localparam int TAIL    = 64;

    localparam t_sample SMP_MAX = 16'sh7FFF;
    localparam t_sample SMP_MIN = 16'sh8000;

    typedef enum int {SEG_NOISE, SEG_HOLD_MAX, SEG_HOLD_MIN, SEG_HOLD, SEG_WOBBLE} t_seg;

    logic    i_clk;
    logic    i_rst_n;
    logic    calm;
    int      sent;
    int      cycle_cnt = 0;
    int      fail_cnt;
    int      pending;
    int      word_cnt;
    int      clip_cnt;
    t_seg    seg_kind;
    int      seg_left;
    t_sample seg_val;

    iir_lp_in_if  smp_ch ();
    iir_lp_out_if flt_ch ();

    iir_lowpass_order7 u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (smp_ch),
        .o_out   (flt_ch)
    );

    iir_lp_check u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_smp      (smp_ch),
        .i_flt      (flt_ch),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending),
        .o_word_cnt (word_cnt),
        .o_clip_cnt (clip_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("tb_iir_lowpass_order7: FAIL");
            $finish;
        end
    end

    // receiver stalls about 30% of cycles except in the calm stretch
    always @(negedge i_clk) begin
        flt_ch.ready = calm || ($urandom_range(99) >= 30);
    end

    // segments: noise, full-scale holds (overload), random holds, small wobble
    function automatic t_sample next_sample();
        t_sample s;
        int      wob;
        if (seg_left == 0) begin
            case ($urandom_range(4))
                0: begin seg_kind = SEG_NOISE;    seg_left = $urandom_range(120, 40); end
                1: begin seg_kind = SEG_HOLD_MAX; seg_left = $urandom_range(300, 100); end
                2: begin seg_kind = SEG_HOLD_MIN; seg_left = $urandom_range(300, 100); end
                3: begin seg_kind = SEG_HOLD;     seg_left = $urandom_range(200, 50); end
                default: begin seg_kind = SEG_WOBBLE; seg_left = $urandom_range(100, 30); end
            endcase
            seg_val = t_sample'($urandom);
        end
        seg_left--;
        case (seg_kind)
            SEG_NOISE:    s = t_sample'($urandom);
            SEG_HOLD_MAX: s = SMP_MAX;
            SEG_HOLD_MIN: s = SMP_MIN;
            SEG_HOLD:     s = seg_val;
            default: begin
                wob = int'(seg_val) + int'($urandom_range(1024)) - 512;
                if (wob > 32767) wob = 32767;
                if (wob < -32768) wob = -32768;
                s = t_sample'(wob);
            end
        endcase
        return s;
    endfunction

    // offer one word, idling at random first, return after it is taken
    task automatic send_sample(input t_sample s);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 30) begin
            smp_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        smp_ch.valid     = 1'b1;
        smp_ch.sample_in = s;
        do @(posedge i_clk); while (!(smp_ch.valid && smp_ch.ready));
        sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        smp_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        t_sample dir_seq [14];
        dir_seq = '{16'sd0, SMP_MAX, SMP_MIN, 16'sd1, -16'sd1, 16'sh5555, 16'shAAAA,
                    16'sd256, -16'sd256, SMP_MAX, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
        smp_ch.valid     = 1'b0;
        smp_ch.sample_in = '0;
        i_rst_n          = 1'b0;
        calm             = 1'b0;
        sent             = 0;
        seg_left         = 0;
        seg_kind         = SEG_NOISE;
        seg_val          = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_seq[i]) send_sample(dir_seq[i]);
        // hold off until the filter has emptied
        wait_drained();

        while (sent < N_ITEMS) begin
            calm = (sent >= 700 && sent < 1000);
            send_sample(next_sample());
        end
        calm = 1'b0;
        wait_drained();
        repeat (TAIL) @(negedge i_clk);

        $display("covered %0d samples: extremes, impulses, full-scale holds, noise, wobble",
                 sent);
        $display("checked %0d filtered words, %0d of them at full scale", word_cnt, clip_cnt);
        if (fail_cnt == 0) begin
            $display("tb_iir_lowpass_order7: PASS");
        end else begin
            $display("tb_iir_lowpass_order7: FAIL");
        end
        $finish;
    end

endmodule
